@@ rtl/keyword_prefix_search_unit_macros.svh @@
// Assertion helpers for the keyword prefix search unit.
// Both macros take a label, the clock, the active-low reset, a property or
// condition and a message string.
`ifndef KEYWORD_PREFIX_SEARCH_UNIT_MACROS_SVH
`define KEYWORD_PREFIX_SEARCH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define KPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KPS_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define KPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define KPS_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/kps_pkg.sv @@
package kps_pkg;

  localparam int CHAR_W      = 7;
  localparam int ENTRY_CHARS = 16;
  localparam int POS_W       = $clog2(ENTRY_CHARS);
  localparam int IDX_W       = 9;
  localparam int CFG_W       = 10;
  localparam int MINLEN_W    = 4;
  localparam int COUNT_W     = 6;
  localparam int LETTERS     = 26;
  localparam int LETTER_W    = 5;

  localparam logic [CHAR_W-1:0] CHAR_A   = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_Z   = 7'h7a;
  localparam logic [CHAR_W-1:0] CHAR_NUL = 7'h00;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic CFG_ENTRIES = 1'b0;
  localparam logic CFG_MIN_LEN = 1'b1;

  localparam logic [MINLEN_W-1:0] MINLEN_RESET = 4'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_CMP,
    S_DONE
  } kps_state_e;

  typedef enum logic [1:0] {
    STATUS_MATCH  = 2'd0,
    STATUS_NONE   = 2'd1,
    STATUS_REJECT = 2'd2
  } kps_status_e;

  // Search command from the front end to the scan sequencer.
  typedef struct packed {
    logic             go;
    logic [POS_W-1:0] last_pos;
    logic             letter_ok;
    logic [IDX_W-1:0] start_idx;
  } kps_cmd_t;

  typedef struct packed {
    logic               strobe;
    logic [IDX_W-1:0]   idx;
    kps_status_e        status;
    logic [COUNT_W-1:0] count;
    logic               last;
  } kps_result_t;

endpackage

@@ rtl/kps_table_mem.sv @@
module kps_table_mem #(
  parameter int DEPTH  = 8192,
  parameter int DATA_W = 7,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/kps_scan_ctrl.sv @@
module kps_scan_ctrl #(
  parameter int TABLE_DEPTH = 512,
  parameter int WORD_CHARS  = 16,
  parameter int LIST_MAX    = 32,
  localparam int TAB_AW = $clog2(TABLE_DEPTH),
  localparam int LIM_W  = $clog2(TABLE_DEPTH + 1),
  localparam int ADDR_W = TAB_AW + kps_pkg::POS_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kps_pkg::kps_cmd_t             cmd_i,
  input  logic [LIM_W-1:0]              limit_i,
  input  logic [kps_pkg::MINLEN_W-1:0]  min_len_i,
  output logic [ADDR_W-1:0]             rd_addr_o,
  input  logic [kps_pkg::CHAR_W-1:0]    rd_data_i,
  output logic [kps_pkg::POS_W-1:0]     q_idx_o,
  input  logic [kps_pkg::CHAR_W-1:0]    q_char_i,
  output logic                          busy_o,
  output kps_pkg::kps_result_t          res_o
);

  import kps_pkg::*;

  localparam int CNT_W = $clog2(LIST_MAX + 1);

  kps_state_e         state_q, state_d;
  logic [LIM_W-1:0]   i_q, i_d;
  logic [POS_W-1:0]   j_q, j_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   pend_q, pend_d;
  logic [POS_W-1:0]   last_pos_q, last_pos_d;
  kps_result_t        res_q, res_d;

  logic               reject;
  logic [LIM_W-1:0]   start_ext;
  logic               start_in;
  logic               char_eq;
  logic               word_done;
  logic [CNT_W-1:0]   cnt_inc;
  logic               list_full;
  logic [LIM_W:0]     i_nxt;
  logic               at_end;

  assign reject    = (last_pos_q < min_len_i) ||
                     ((32'(last_pos_q) + 32'd2) >= 32'(WORD_CHARS));
  assign start_ext = LIM_W'(cmd_i.start_idx);
  assign start_in  = start_ext < limit_i;
  assign char_eq   = (rd_data_i != CHAR_NUL) && (rd_data_i == q_char_i);
  assign word_done = j_q == last_pos_q;
  assign cnt_inc   = cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};
  assign list_full = cnt_inc == CNT_W'(LIST_MAX);
  assign i_nxt     = {1'b0, i_q} + {{LIM_W{1'b0}}, 1'b1};
  assign at_end    = i_nxt >= {1'b0, limit_i};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_i.go) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (reject || !cmd_i.letter_ok || !start_in) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (char_eq && !word_done) begin
          state_d = S_READ;
        end else if (char_eq) begin
          state_d = (list_full || at_end) ? S_DONE : S_READ;
        end else begin
          state_d = ((cnt_q != '0) || at_end) ? S_DONE : S_READ;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath and results.
  always_comb begin
    i_d        = i_q;
    j_d        = j_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    last_pos_d = last_pos_q;
    res_d      = '0;
    case (state_q)
      S_IDLE: begin
        if (cmd_i.go) begin
          last_pos_d = cmd_i.last_pos;
          cnt_d      = '0;
        end
      end
      S_CHECK: begin
        i_d = start_ext;
        j_d = '0;
        if (reject) begin
          res_d.strobe = 1'b1;
          res_d.status = STATUS_REJECT;
          res_d.last   = 1'b1;
        end else if (!cmd_i.letter_ok || !start_in) begin
          res_d.strobe = 1'b1;
          res_d.status = STATUS_NONE;
          res_d.last   = 1'b1;
        end
      end
      S_CMP: begin
        if (char_eq && !word_done) begin
          j_d = j_q + {{(POS_W-1){1'b0}}, 1'b1};
        end else begin
          if (char_eq) begin
            // A new hit proves the held one was not the last of the list.
            if (cnt_q != '0) begin
              res_d.strobe = 1'b1;
              res_d.idx    = pend_q;
              res_d.status = STATUS_MATCH;
              res_d.count  = COUNT_W'(cnt_q);
            end
            pend_d = IDX_W'(i_q);
            cnt_d  = cnt_inc;
          end
          i_d = i_nxt[LIM_W-1:0];
          j_d = '0;
        end
      end
      S_DONE: begin
        res_d.strobe = 1'b1;
        res_d.last   = 1'b1;
        if (cnt_q == '0) begin
          res_d.status = STATUS_NONE;
        end else begin
          res_d.idx    = pend_q;
          res_d.status = STATUS_MATCH;
          res_d.count  = COUNT_W'(cnt_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    cnt_q      <= cnt_d;
    pend_q     <= pend_d;
    last_pos_q <= last_pos_d;
  end

  assign rd_addr_o = {i_q[TAB_AW-1:0], j_q};
  assign q_idx_o   = j_q;
  assign busy_o    = state_q != S_IDLE;
  assign res_o     = res_q;

endmodule

@@ rtl/keyword_prefix_search_unit.sv @@
// Keyword prefix search unit.
// Command channel: an item is taken at a rising edge with start high and busy
// low. A load item (req_type_i low) writes one character of a table entry and
// is finished in that cycle; a query item stores one character of the word,
// and one with word_end_i high also launches the search and raises busy.
// Load items and non-final query characters can follow every cycle when idle.
// Results leave on match_index_o, status_o, match_count_o and last_result_o,
// each shown for exactly one cycle with result_strobe_o high. The receiver
// cannot stall, so every result is a completed transfer in its cycle.
// A rejected length, or a word whose first letter has no start in the entries
// in use, gives its single result, registered from the check state. Otherwise
// each compared character takes a read state (a read of the table memory)
// and a compare state (the shared comparator); each hit is released once the next
// entry has been judged, and the final result is registered from the done
// state after the scan ends. busy falls in the cycle that shows the final result.
// Configuration writes are transfers on cfg_valid_i/cfg_ready_o and are taken
// only while the unit is idle. Reset clears the letter starts to invalid, the
// query word to zero and the registers to their defaults; the table itself
// holds no defined contents until written, and no clearing pass is needed.
`include "keyword_prefix_search_unit_macros.svh"

module keyword_prefix_search_unit #(
  parameter int TABLE_DEPTH = 512,
  parameter int WORD_CHARS  = 16,
  parameter int LIST_MAX    = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type_i,
  input  logic [kps_pkg::IDX_W-1:0]     entry_index_i,
  input  logic [kps_pkg::POS_W-1:0]     char_pos_i,
  input  logic [kps_pkg::CHAR_W-1:0]    char_value_i,
  input  logic                          word_end_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [kps_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                          result_strobe_o,
  output logic [kps_pkg::IDX_W-1:0]     match_index_o,
  output logic [1:0]                    status_o,
  output logic [kps_pkg::COUNT_W-1:0]   match_count_o,
  output logic                          last_result_o
);

  import kps_pkg::*;

  localparam int TAB_AW    = $clog2(TABLE_DEPTH);
  localparam int LIM_W     = $clog2(TABLE_DEPTH + 1);
  localparam int MEM_DEPTH = TABLE_DEPTH * ENTRY_CHARS;
  localparam int ADDR_W    = TAB_AW + POS_W;
  localparam int QW        = $clog2(WORD_CHARS);

  logic                  accept;
  logic                  load_we;
  logic                  query_we;
  logic                  cfg_we;
  logic [CFG_W-1:0]      entries_q;
  logic [MINLEN_W-1:0]   min_len_q;
  logic [LIM_W-1:0]      limit;

  logic [CHAR_W-1:0]     query_q [WORD_CHARS];
  logic [IDX_W-1:0]      letter_start_q [LETTERS];
  logic [LETTERS-1:0]    letter_valid_q;

  logic                  ld_is_letter;
  logic [LETTER_W-1:0]   ld_letter;
  logic                  ld_lower;

  logic [CHAR_W-1:0]     first_char;
  logic                  first_is_letter;
  logic [LETTER_W-1:0]   first_letter;

  kps_cmd_t              cmd;
  kps_result_t           res;
  logic [ADDR_W-1:0]     rd_addr;
  logic [CHAR_W-1:0]     rd_data;
  logic [POS_W-1:0]      q_idx;
  logic [CHAR_W-1:0]     q_char;

  assign accept   = start && !busy;
  assign load_we  = accept && (req_type_i == REQ_LOAD) &&
                    (32'(entry_index_i) < 32'(TABLE_DEPTH));
  assign query_we = accept && (req_type_i == REQ_QUERY);
  assign cfg_we   = cfg_valid_i && cfg_ready_o;

  assign cfg_ready_o = !busy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
      min_len_q <= MINLEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_ENTRIES: entries_q <= cfg_data_i;
        CFG_MIN_LEN: min_len_q <= cfg_data_i[MINLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Entries in use beyond the table depth behave as the full table.
  assign limit = (32'(entries_q) > 32'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH)
                                                     : LIM_W'(entries_q);

  // Query word store; characters beyond the store are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WORD_CHARS; k++) begin
        query_q[k] <= CHAR_NUL;
      end
    end else if (query_we && (32'(char_pos_i) < 32'(WORD_CHARS))) begin
      query_q[QW'(char_pos_i)] <= char_value_i;
    end
  end

  assign q_char = (32'(q_idx) < 32'(WORD_CHARS)) ? query_q[QW'(q_idx)] : CHAR_NUL;

  // Letter start table. A start only ever moves to a lower entry index.
  assign ld_lower     = char_value_i inside {[CHAR_A:CHAR_Z]};
  assign ld_letter    = ld_lower ? LETTER_W'(char_value_i - CHAR_A) : '0;
  assign ld_is_letter = load_we && (char_pos_i == '0) && ld_lower &&
                        (!letter_valid_q[ld_letter] ||
                         (entry_index_i < letter_start_q[ld_letter]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_valid_q <= '0;
    end else if (ld_is_letter) begin
      letter_valid_q[ld_letter] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_is_letter) begin
      letter_start_q[ld_letter] <= entry_index_i;
    end
  end

  // The first letter is looked up from the stored word in the check state after launch.
  assign first_char      = query_q[0];
  assign first_is_letter = first_char inside {[CHAR_A:CHAR_Z]};
  assign first_letter    = first_is_letter ? LETTER_W'(first_char - CHAR_A) : '0;

  assign cmd.go        = query_we && word_end_i;
  assign cmd.last_pos  = char_pos_i;
  assign cmd.letter_ok = first_is_letter && letter_valid_q[first_letter];
  assign cmd.start_idx = letter_start_q[first_letter];

  kps_table_mem #(
    .DEPTH  (MEM_DEPTH),
    .DATA_W (CHAR_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i ({TAB_AW'(entry_index_i), char_pos_i}),
    .wdata_i (char_value_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  kps_scan_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .WORD_CHARS  (WORD_CHARS),
    .LIST_MAX    (LIST_MAX)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .limit_i   (limit),
    .min_len_i (min_len_q),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .q_idx_o   (q_idx),
    .q_char_i  (q_char),
    .busy_o    (busy),
    .res_o     (res)
  );

  assign result_strobe_o = res.strobe;
  assign match_index_o   = res.idx;
  assign status_o        = res.status;
  assign match_count_o   = res.count;
  assign last_result_o   = res.last;

  // Results only come out of a search that was running in the previous cycle.
  `KPS_ASSERT(a_result_from_search, clk_i, rst_ni, result_strobe_o |-> $past(busy), "result without a running search")
  // A rejection or a miss is always a lone, final result with a zero count.
  `KPS_ASSERT(a_fail_is_final, clk_i, rst_ni, (result_strobe_o && (status_o != STATUS_MATCH)) |-> (last_result_o && (match_count_o == '0)), "failed search result is not final")
  // The unit only goes busy on an accepted command.
  `KPS_ASSERT(a_busy_from_start, clk_i, rst_ni, $rose(busy) |-> $past(start), "busy raised without a command")

endmodule

@@ bench/keyword_prefix_search_unit_tb.sv @@
// Self-checking bench for the keyword prefix search unit.
//
// The bench keeps its own copy of the keyword table, the per-letter start
// indices, the query word and both registers. Every item that the unit takes
// updates that copy. A final query character then works out the full list of
// results that the unit should emit, and the list is queued. A separate
// process compares each result strobe with the oldest queued result, field by
// field.
//
// The table is always loaded completely (every character of every entry)
// before any search can reach it, so the unit never reads an entry that was
// never written. After that the run mixes well-formed queries built from
// table prefixes, random words, broken query sequences and table rewrites,
// and moves through several register settings between phases.
module keyword_prefix_search_unit_tb;
  import kps_pkg::*;

  localparam int TABLE_DEPTH  = 512;
  localparam int WORD_CHARS   = 16;
  localparam int LIST_MAX     = 32;
  localparam int RANDOM_ITEMS = 300;
  // A search without hits may walk the whole table, comparing up to fourteen
  // characters per entry, so the quiet limit is generous.
  localparam int QUIET_LIMIT  = 150000;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LBRACE = 7'h7b;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    kps_status_e        status;
    logic [COUNT_W-1:0] count;
    logic               last;
  } search_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                req_type_i;
  logic [IDX_W-1:0]    entry_index_i;
  logic [POS_W-1:0]    char_pos_i;
  logic [CHAR_W-1:0]   char_value_i;
  logic                word_end_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic                cfg_index_i;
  logic [CFG_W-1:0]    cfg_data_i;
  logic                result_strobe_o;
  logic [IDX_W-1:0]    match_index_o;
  logic [1:0]          status_o;
  logic [COUNT_W-1:0]  match_count_o;
  logic                last_result_o;

  // Bench copy of the unit's state.
  logic [CHAR_W-1:0]   kw_table [TABLE_DEPTH][ENTRY_CHARS];
  bit                  start_ok [LETTERS];
  logic [IDX_W-1:0]    start_idx [LETTERS];
  logic [CHAR_W-1:0]   word_chars [WORD_CHARS];
  logic [CFG_W-1:0]    cfg_entries;
  logic [MINLEN_W-1:0] cfg_min_len;

  search_result_t      expected_results [$];
  logic [CHAR_W-1:0]   word_buf [ENTRY_CHARS];

  int mismatches;
  int items_sent;
  int words_searched;
  int results_seen;
  int cfg_writes;
  int quiet_cycles;
  bit steady;

  keyword_prefix_search_unit #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .WORD_CHARS  (WORD_CHARS),
    .LIST_MAX    (LIST_MAX)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .entry_index_i   (entry_index_i),
    .char_pos_i      (char_pos_i),
    .char_value_i    (char_value_i),
    .word_end_i      (word_end_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_strobe_o (result_strobe_o),
    .match_index_o   (match_index_o),
    .status_o        (status_o),
    .match_count_o   (match_count_o),
    .last_result_o   (last_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  task automatic queue_result(input logic [IDX_W-1:0] idx, input kps_status_e status,
                              input logic [COUNT_W-1:0] count, input logic last);
    search_result_t r;
    r.idx    = idx;
    r.status = status;
    r.count  = count;
    r.last   = last;
    expected_results.push_back(r);
  endtask

  // An entry matches when every word character up to the length is present
  // in the entry; a padding zero or any differing character ends the match.
  function automatic bit entry_has_prefix(int e, int len);
    for (int j = 0; j < len; j++) begin
      if (j >= ENTRY_CHARS) return 1'b0;
      if (kw_table[e][j] == CHAR_NUL || kw_table[e][j] != word_chars[j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic table_write(input logic [IDX_W-1:0] entry, input logic [POS_W-1:0] pos,
                             input logic [CHAR_W-1:0] ch);
    int l;
    if (entry < TABLE_DEPTH) begin
      kw_table[entry][pos] = ch;
      // A letter in the first position may pull that letter's start down,
      // but a start is never moved up again.
      if (pos == 0 && ch >= CHAR_A && ch <= CHAR_Z) begin
        l = ch - CHAR_A;
        if (!start_ok[l] || entry < start_idx[l]) begin
          start_idx[l] = entry;
          start_ok[l]  = 1'b1;
        end
      end
    end
  endtask

  task automatic search_word(input logic [POS_W-1:0] pos, input logic [CHAR_W-1:0] ch,
                             input logic wend);
    int len;
    int lim;
    int first;
    int hits [$];
    if (pos < WORD_CHARS) word_chars[pos] = ch;
    if (!wend) return;
    words_searched++;
    len = pos + 1;
    // Too short for the current minimum, or too long for the word store.
    if (len <= cfg_min_len || len + 1 >= WORD_CHARS) begin
      queue_result('0, STATUS_REJECT, '0, 1'b1);
      return;
    end
    first = word_chars[0];
    if (first < CHAR_A || first > CHAR_Z || !start_ok[first - CHAR_A]) begin
      queue_result('0, STATUS_NONE, '0, 1'b1);
      return;
    end
    // Register values above the table size act as the full table.
    lim = (cfg_entries > TABLE_DEPTH) ? TABLE_DEPTH : cfg_entries;
    for (int i = start_idx[first - CHAR_A]; i < lim; i++) begin
      if (hits.size() >= LIST_MAX) break;
      if (entry_has_prefix(i, len)) hits.push_back(i);
      else if (hits.size() != 0) break;
    end
    if (hits.size() == 0) begin
      queue_result('0, STATUS_NONE, '0, 1'b1);
    end else begin
      foreach (hits[k]) queue_result(hits[k], STATUS_MATCH, k + 1, k == hits.size() - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driving. Every task below is entered and left just after a falling edge.
  // ---------------------------------------------------------------------------

  // Offers one item and holds it until the transfer completes. start is left
  // high so that a following item can go out in the very next cycle.
  task automatic send_item(input logic req, input logic [IDX_W-1:0] entry,
                           input logic [POS_W-1:0] pos, input logic [CHAR_W-1:0] ch,
                           input logic wend);
    req_type_i    <= req;
    entry_index_i <= entry;
    char_pos_i    <= pos;
    char_value_i  <= ch;
    word_end_i    <= wend;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    items_sent++;
    if (req == REQ_LOAD) table_write(entry, pos, ch);
    else search_word(pos, ch, wend);
    @(negedge clk_i);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Mostly back-to-back, sometimes a short gap, now and then a long one.
  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_letter();
    return CHAR_A + $urandom_range(0, LETTERS - 1);
  endfunction

  task automatic write_reg(input logic index, input logic [CFG_W-1:0] data);
    cfg_index_i <= index;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (index == CFG_ENTRIES) cfg_entries = data;
    else cfg_min_len = data[MINLEN_W-1:0];
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Waits until every queued result has come back, then lets the unit wind
  // down before the registers are touched.
  task automatic settle();
    start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Sends word_buf[0 .. len-1] as a query, word end on the last character.
  // The entry index of a query item is ignored, so it carries random bits.
  task automatic send_buf(input int len);
    for (int k = 0; k < len; k++) begin
      send_item(REQ_QUERY, $urandom_range(0, TABLE_DEPTH - 1), k, word_buf[k],
                k == len - 1);
      pause(gap_len());
    end
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) word_buf[k] = CHAR_W'(s[k]);
    send_buf(s.len());
  endtask

  // Copies an entry into word_buf and returns its length up to the padding.
  function automatic int copy_entry(int e);
    int n;
    n = ENTRY_CHARS;
    for (int j = ENTRY_CHARS - 1; j >= 0; j--) begin
      word_buf[j] = kw_table[e][j];
      if (kw_table[e][j] == CHAR_NUL) n = j;
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight out of reset no letter has a start, so nothing reaches the table.
  task automatic test_reset_state();
    send_text("ab");
    send_text("a");
    send_item(REQ_QUERY, '1, '1, CHAR_A, 1'b1);
    settle();
    write_reg(CFG_MIN_LEN, 10'd0);
    send_text("z");
    settle();
  endtask

  // Loads all entries in alphabetical order. The first group begins with
  // digits and punctuation, the last with characters above the letters, and
  // q, x and z are never used as a first letter. Three groups share the
  // letter m, so a one-letter query on m runs into the list limit.
  task automatic test_load_table();
    string letters;
    logic [CHAR_W-1:0] word [ENTRY_CHARS];
    int grp;
    int sub;
    int p0;
    int tail;
    letters = "abccdeefghijklmmmnoprssttuvwwy";
    sub = 0;
    write_reg(CFG_ENTRIES, TABLE_DEPTH);
    for (int e = 0; e < TABLE_DEPTH; e++) begin
      grp = e / 16;
      if (e % 16 == 0) begin
        if (grp >= 2 && grp <= 30 && letters[grp - 1] == letters[grp - 2]) sub++;
        else sub = 0;
      end
      foreach (word[j]) word[j] = CHAR_NUL;
      if (grp == 0) begin
        word[0] = CHAR_ZERO + e % 16;
        p0 = 1;
      end else if (grp == 31) begin
        word[0] = CHAR_LBRACE + (e % 16) / 4;
        word[1] = CHAR_A + (e % 4) * 6 + $urandom_range(0, 5);
        p0 = 2;
      end else begin
        word[0] = CHAR_W'(letters[grp - 1]);
        word[1] = CHAR_A + sub * 4 + (e % 16) / 4;
        word[2] = CHAR_A + (e % 4) * 6 + $urandom_range(0, 5);
        p0 = 3;
      end
      tail = $urandom_range(0, ENTRY_CHARS - p0);
      for (int j = p0; j < p0 + tail; j++) word[j] = rand_letter();
      steady = ($urandom_range(0, 3) != 0);
      for (int j = 0; j < ENTRY_CHARS; j++) begin
        send_item(REQ_LOAD, e, j, word[j], $urandom_range(0, 1));
        pause(gap_len());
      end
    end
    steady = 1'b0;
    settle();
  endtask

  task automatic test_directed_search();
    int n;
    // One letter shared by three groups: the list limit ends the scan.
    send_text("m");
    // A real entry: hits stop at the first mismatch after the last hit.
    n = copy_entry(200);
    send_buf((n > 6) ? 6 : n);
    // A letter without a start, and a first character that is no letter.
    send_text("qu");
    send_text("Ab");
    // Never present: the scan runs to the end of the entries in use.
    send_text("mzz");
    // Longest searchable word, then the first lengths that are rejected.
    send_item(REQ_QUERY, '0, 4'd13, CHAR_Z, 1'b1);
    send_item(REQ_QUERY, '0, 4'd14, CHAR_Z, 1'b1);
    send_item(REQ_QUERY, '1, 4'd15, CHAR_Z, 1'b1);
    settle();
    write_reg(CFG_MIN_LEN, 10'h3ff);
    send_text("ab");
    settle();
    write_reg(CFG_MIN_LEN, 10'd0);
    write_reg(CFG_ENTRIES, 10'd0);
    send_text("ab");
    settle();
    write_reg(CFG_ENTRIES, 10'h3ff);
    send_text("ma");
    settle();
    // The entries in use end inside the group of a, ahead of its ab entries.
    write_reg(CFG_ENTRIES, 10'd20);
    send_text("ab");
    settle();
  endtask

  task automatic pick_settings();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       write_reg(CFG_ENTRIES, 10'd0);
      1:       write_reg(CFG_ENTRIES, 10'h3ff);
      2:       write_reg(CFG_ENTRIES, $urandom_range(0, TABLE_DEPTH - 1));
      3:       write_reg(CFG_ENTRIES, $urandom_range(TABLE_DEPTH + 1, 1023));
      default: write_reg(CFG_ENTRIES, TABLE_DEPTH);
    endcase
    r = $urandom_range(0, 9);
    // The upper data bits carry noise; only the low four reach the register.
    case (r)
      0:       write_reg(CFG_MIN_LEN, {$urandom_range(0, 63), 4'd15});
      1:       write_reg(CFG_MIN_LEN, {$urandom_range(0, 63), 4'($urandom_range(3, 14))});
      default: write_reg(CFG_MIN_LEN, {$urandom_range(0, 63), 4'($urandom_range(0, 2))});
    endcase
  endtask

  // Mostly well-formed queries drawn from the table, some of them spoiled in
  // one character, plus random words, broken sequences and table rewrites.
  task automatic test_random_traffic();
    int first_item;
    int next_phase;
    int r;
    int e;
    int n;
    int len;
    first_item = items_sent;
    next_phase = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if (items_sent >= next_phase) begin
        settle();
        pick_settings();
        next_phase = items_sent + $urandom_range(30, 60);
      end
      steady = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 60) begin
        e = $urandom_range(0, TABLE_DEPTH - 1);
        n = copy_entry(e);
        if (n == 0) begin
          word_buf[0] = rand_letter();
          n = 1;
        end
        len = $urandom_range(1, (n > 14) ? 14 : n);
        if ($urandom_range(0, 3) == 0) word_buf[$urandom_range(0, len - 1)] = rand_letter();
        send_buf(len);
      end else if (r < 75) begin
        len = $urandom_range(1, ENTRY_CHARS);
        for (int k = 0; k < len; k++) word_buf[k] = rand_letter();
        send_buf(len);
      end else if (r < 88) begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          send_item(REQ_QUERY, $urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, 15),
                    $urandom_range(0, 127), $urandom_range(0, 1));
          pause(gap_len());
        end
      end else begin
        send_item(REQ_LOAD, $urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, 15),
                  $urandom_range(0, 1) ? rand_letter() : CHAR_W'($urandom_range(0, 127)),
                  $urandom_range(0, 1));
        pause(gap_len());
      end
    end
    steady = 1'b0;
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: the receiver cannot stall, so every strobe is a transfer.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    search_result_t want;
    if (rst_ni && result_strobe_o === 1'b1) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: unexpected result idx=%0d status=%0d count=%0d last=%0b",
                   match_index_o, status_o, match_count_o, last_result_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (match_index_o !== want.idx || status_o !== want.status ||
            match_count_o !== want.count || last_result_o !== want.last) begin
          if (mismatches < 10)
            $display("ERROR: result %0d expected idx=%0d status=%0d count=%0d last=%0b, %s",
                     results_seen, want.idx, want.status, want.count, want.last,
                     $sformatf("got idx=%0d status=%0d count=%0d last=%0b",
                               match_index_o, status_o, match_count_o, last_result_o));
          mismatches++;
        end
      end
    end
  end

  // Counts cycles in which no transfer of any kind completes.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else if ((start && !busy) || result_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_type_i    = REQ_LOAD;
    entry_index_i = '0;
    char_pos_i    = '0;
    char_value_i  = CHAR_NUL;
    word_end_i    = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_ENTRIES;
    cfg_data_i    = '0;
    foreach (start_ok[l]) start_ok[l] = 1'b0;
    foreach (start_idx[l]) start_idx[l] = '0;
    foreach (word_chars[j]) word_chars[j] = CHAR_NUL;
    cfg_entries   = '0;
    cfg_min_len   = MINLEN_RESET;
    mismatches    = 0;
    items_sent    = 0;
    words_searched = 0;
    results_seen  = 0;
    cfg_writes    = 0;
    steady        = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_load_table();
    test_directed_search();
    test_random_traffic();

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_results.size() != 0) begin
      $display("ERROR: %0d results never arrived", expected_results.size());
      mismatches++;
    end
    $display("Covered %0d items with %0d searched words, %0d results and %0d register writes.",
             items_sent, words_searched, results_seen, cfg_writes);
    $display("Mismatches found: %0d", mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
